// File: design/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

  // Table and pool geometry.
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 20;
  localparam int SIZE_W     = ADDR_W + 1;

  localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOFIT    = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  // One block of the table.
  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_INIT   = 2'd2,
    CMD_EDIT   = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_LEFT1  = 2'd1,
    SH_LEFT2  = 2'd2,
    SH_RIGHT1 = 2'd3
  } shift_t;

  // Command broadcast to every cell of the ring.
  typedef struct packed {
    cell_op_t         op;
    shift_t           shift;
    logic [CNT_W-1:0] shift_pos;
    logic             w0_en;
    logic [CNT_W-1:0] w0_pos;
    entry_t           w0_ent;
    logic             w1_en;
    logic [CNT_W-1:0] w1_pos;
    entry_t           w1_ent;
  } cell_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] off;
    logic              moved;
    logic [SIZE_W-1:0] len;
  } result_t;

endpackage

// File: design/ffba_if.sv
`timescale 1ns / 1ps

// Request channel.
interface ffba_in_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_offset;
  modport source(output valid, action, request_size, block_offset, input ready);
  modport sink(input valid, action, request_size, block_offset, output ready);
endinterface

// Result channel.
interface ffba_out_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] result_offset;
  logic              moved;
  logic [SIZE_W-1:0] copy_length;
  modport source(output valid, status, result_offset, moved, copy_length, input ready);
  modport sink(input valid, status, result_offset, moved, copy_length, output ready);
endinterface

// Pool size write channel.
interface ffba_cfg_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: design/ffba_cell.sv
`timescale 1ns / 1ps

module ffba_cell import ffba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cell_idx,
  input  cell_cmd_t        cmd,
  input  entry_t           from_next,
  input  entry_t           from_next2,
  input  entry_t           from_prev,
  output entry_t           ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Select what this cell holds next: hold, rotate, initialise, write or shift.
  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      CMD_HOLD:   ent_nxt = ent_r;
      CMD_ROTATE: ent_nxt = from_next;
      CMD_INIT: begin
        if (cell_idx == '0) ent_nxt = cmd.w0_ent;
      end
      CMD_EDIT: begin
        if (cmd.w0_en && cmd.w0_pos == cell_idx) begin
          ent_nxt = cmd.w0_ent;
        end else if (cmd.w1_en && cmd.w1_pos == cell_idx) begin
          ent_nxt = cmd.w1_ent;
        end else if (cell_idx >= cmd.shift_pos) begin
          case (cmd.shift)
            SH_LEFT1:  ent_nxt = from_next;
            SH_LEFT2:  ent_nxt = from_next2;
            SH_RIGHT1: ent_nxt = from_prev;
            default:   ent_nxt = ent_r;
          endcase
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // Only the first cell has a defined reset value: the whole pool, free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if (cell_idx == '0) ent_r <= '{off: '0, size: POOL_MAX, free: 1'b1};
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

// File: design/ffba_chain.sv
`timescale 1ns / 1ps

module ffba_chain import ffba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  output entry_t    head,
  output entry_t    second
);

  entry_t ents [MAX_BLOCKS];

  // A closed ring: each cell sees its two right neighbours and its left one.
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    localparam int KN1 = (k + 1) % MAX_BLOCKS;
    localparam int KN2 = (k + 2) % MAX_BLOCKS;
    localparam int KP1 = (k + MAX_BLOCKS - 1) % MAX_BLOCKS;
    ffba_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CNT_W'(k)),
      .cmd       (cmd),
      .from_next (ents[KN1]),
      .from_next2(ents[KN2]),
      .from_prev (ents[KP1]),
      .ent       (ents[k])
    );
  end

  assign head   = ents[0];
  assign second = ents[1 % MAX_BLOCKS];

endmodule

// File: design/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Carries
// in_item   sink       action, request_size, block_offset
// out_item  source     status, result_offset, moved, copy_length
// cfg_wr    sink       data (pool size)
//
// An item takes one full revolution of the cell ring, during which the head
// cell is examined, then the edit state, and the result is registered. A resize
// that moves takes a second revolution. Reset is synchronous, active low, and
// leaves one free block covering the whole pool. Items are taken only between
// revolutions; a new item may enter while the previous result still waits.

module first_fit_block_allocator_core import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ffba_in_if.sink     in_item,
  ffba_out_if.source  out_item,
  ffba_cfg_if.sink    cfg_wr
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EDIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_BLOCKS - 1);

  state_t            state_r;
  logic [IDX_W-1:0]  scan_r;
  logic [CNT_W-1:0]  count_r;
  action_t           act_r;
  logic [SIZE_W-1:0] req_r;
  logic [ADDR_W-1:0] boff_r;
  logic              pass2_r;
  entry_t            prev_r;
  logic              fa_r;
  logic [IDX_W-1:0]  a_idx_r;
  entry_t            a_ent_r;
  logic              ff_r;
  logic [IDX_W-1:0]  f_idx_r;
  entry_t            f_cur_r;
  entry_t            f_nxt_r;
  logic              f_nv_r;
  entry_t            f_prev_r;
  result_t           res_r;
  result_t           res_nxt;
  result_t           out_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              go_pass2;

  cell_cmd_t cmd;
  entry_t    head;
  entry_t    second;

  logic in_acc;
  logic cfg_acc;
  logic out_load;

  assign cfg_wr.ready   = (state_r == ST_IDLE);
  assign in_item.ready  = (state_r == ST_IDLE) && !cfg_wr.valid;
  assign cfg_acc        = cfg_wr.valid && cfg_wr.ready;
  assign in_acc         = in_item.valid && in_item.ready;
  assign out_load       = (state_r == ST_DONE) && (!out_valid_r || out_item.ready);

  ffba_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .head  (head),
    .second(second)
  );

  // Scan-time tests on the head cell.
  logic [CNT_W-1:0] scan_pos;
  logic             scan_v;
  logic             scan_vn;
  logic             want_alloc;
  logic             want_find;

  assign scan_pos   = CNT_W'(scan_r);
  assign scan_v     = scan_pos < count_r;
  assign scan_vn    = (scan_pos + CNT_W'(1)) < count_r;
  assign want_alloc = (act_r == ACT_ALLOC) || (act_r == ACT_RESIZE && !pass2_r);
  assign want_find  = (act_r == ACT_FREE) || (act_r == ACT_RESIZE);

  // Allocation arithmetic on the first fitting block.
  logic [SIZE_W-1:0] a_rest;
  logic              a_split;
  logic              a_full;
  logic              a_ok;
  status_t           a_status;
  logic [CNT_W-1:0]  a_pos;

  assign a_rest   = a_ent_r.size - req_r;
  assign a_split  = (a_rest != '0);
  assign a_full   = (count_r >= CNT_W'(MAX_BLOCKS));
  assign a_ok     = fa_r && !(a_split && a_full);
  assign a_status = !fa_r ? STS_NOFIT : ((a_split && a_full) ? STS_FULL : STS_OK);
  assign a_pos    = CNT_W'(a_idx_r);

  // Free and resize arithmetic on the located block.
  logic              f_a;
  logic              f_b;
  logic [SIZE_W-1:0] f_new;
  logic [SIZE_W-1:0] f_merged;
  logic [SIZE_W:0]   r_total;
  logic              r_fits;
  logic              r_grow;
  logic [CNT_W-1:0]  f_pos;

  assign f_a      = f_nv_r && f_nxt_r.free;
  assign f_b      = (f_idx_r != '0) && f_prev_r.free;
  assign f_new    = f_cur_r.size + (f_a ? f_nxt_r.size : '0);
  assign f_merged = f_prev_r.size + f_new;
  assign r_total  = {1'b0, f_cur_r.size} + {1'b0, f_nxt_r.size};
  assign r_fits   = (f_cur_r.size >= req_r);
  assign r_grow   = f_nv_r && f_nxt_r.free && (r_total >= {1'b0, req_r});
  assign f_pos    = CNT_W'(f_idx_r);

  logic [SIZE_W-1:0] pool_val;
  assign pool_val = (cfg_wr.data == '0) ? SIZE_W'(1) :
                    ((cfg_wr.data > POOL_MAX) ? POOL_MAX : cfg_wr.data);

  // Ring command and the outcome of the edit cycle.
  always_comb begin
    cmd       = '0;
    cmd.op    = CMD_HOLD;
    cmd.shift = SH_NONE;
    res_nxt   = res_r;
    count_nxt = count_r;
    go_pass2  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          cmd.op     = CMD_INIT;
          cmd.w0_ent = '{off: '0, size: pool_val, free: 1'b1};
        end
      end
      ST_SCAN: cmd.op = CMD_ROTATE;
      ST_EDIT: begin
        cmd.op = CMD_EDIT;
        if (want_alloc && (act_r == ACT_ALLOC || (ff_r && !r_fits && !r_grow))) begin
          // First-fit allocation, directly or as the relocation of a resize.
          res_nxt = '{status: a_status, off: '0, moved: 1'b0, len: '0};
          if (a_ok) begin
            res_nxt.off = a_ent_r.off;
            cmd.w0_en   = 1'b1;
            cmd.w0_pos  = a_pos;
            cmd.w0_ent  = '{off: a_ent_r.off, size: a_split ? req_r : a_ent_r.size,
                            free: 1'b0};
            if (a_split) begin
              cmd.w1_en     = 1'b1;
              cmd.w1_pos    = a_pos + CNT_W'(1);
              cmd.w1_ent    = '{off: a_ent_r.off + req_r[ADDR_W-1:0], size: a_rest,
                                free: 1'b1};
              cmd.shift     = SH_RIGHT1;
              cmd.shift_pos = a_pos + CNT_W'(2);
              count_nxt     = count_r + CNT_W'(1);
            end
            if (act_r == ACT_RESIZE) begin
              res_nxt.moved = 1'b1;
              res_nxt.len   = f_cur_r.size;
              go_pass2      = 1'b1;
            end
          end
        end else if (!ff_r) begin
          res_nxt = '{status: STS_NOTFOUND, off: '0, moved: 1'b0, len: '0};
        end else if (act_r == ACT_FREE || pass2_r) begin
          // Mark free, merge with a free successor, then with a free predecessor.
          if (!pass2_r) res_nxt = '{status: STS_OK, off: '0, moved: 1'b0, len: '0};
          cmd.w0_en = 1'b1;
          if (f_b) begin
            cmd.w0_pos    = f_pos - CNT_W'(1);
            cmd.w0_ent    = '{off: f_prev_r.off, size: f_merged, free: 1'b1};
            cmd.shift     = f_a ? SH_LEFT2 : SH_LEFT1;
            cmd.shift_pos = f_pos;
            count_nxt     = count_r - (f_a ? CNT_W'(2) : CNT_W'(1));
          end else begin
            cmd.w0_pos = f_pos;
            cmd.w0_ent = '{off: f_cur_r.off, size: f_new, free: 1'b1};
            if (f_a) begin
              cmd.shift     = SH_LEFT1;
              cmd.shift_pos = f_pos + CNT_W'(1);
              count_nxt     = count_r - CNT_W'(1);
            end
          end
        end else begin
          // Resize in place: already big enough, or grow into the free successor.
          res_nxt = '{status: STS_OK, off: f_cur_r.off, moved: 1'b0, len: '0};
          if (!r_fits) begin
            cmd.w0_en  = 1'b1;
            cmd.w0_pos = f_pos;
            cmd.w0_ent = '{off: f_cur_r.off, size: req_r, free: f_cur_r.free};
            if (r_total > {1'b0, req_r}) begin
              cmd.w1_en  = 1'b1;
              cmd.w1_pos = f_pos + CNT_W'(1);
              cmd.w1_ent = '{off: f_cur_r.off + req_r[ADDR_W-1:0],
                             size: SIZE_W'(r_total - {1'b0, req_r}), free: 1'b1};
            end else begin
              cmd.shift     = SH_LEFT1;
              cmd.shift_pos = f_pos + CNT_W'(1);
              count_nxt     = count_r - CNT_W'(1);
            end
          end
        end
      end
      ST_DONE: cmd.op = CMD_HOLD;
      default: cmd.op = CMD_HOLD;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      pass2_r     <= 1'b0;
      fa_r        <= 1'b0;
      ff_r        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (cfg_acc) count_r <= CNT_W'(1);
          if (in_acc) begin
            act_r   <= action_t'(in_item.action);
            req_r   <= in_item.request_size;
            boff_r  <= in_item.block_offset;
            pass2_r <= 1'b0;
            fa_r    <= 1'b0;
            ff_r    <= 1'b0;
            scan_r  <= '0;
            if (action_t'(in_item.action) == ACT_NOP) begin
              res_r   <= '{status: STS_OK, off: '0, moved: 1'b0, len: '0};
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          prev_r <= head;
          if (want_alloc && !fa_r && scan_v && head.free && head.size >= req_r) begin
            fa_r    <= 1'b1;
            a_idx_r <= scan_r;
            a_ent_r <= head;
          end
          if (want_find && !ff_r && scan_v && head.off == boff_r) begin
            ff_r     <= 1'b1;
            f_idx_r  <= scan_r;
            f_cur_r  <= head;
            f_nxt_r  <= second;
            f_nv_r   <= scan_vn;
            f_prev_r <= prev_r;
          end
          scan_r <= scan_r + IDX_W'(1);
          if (scan_r == SCAN_LAST) state_r <= ST_EDIT;
        end
        ST_EDIT: begin
          res_r   <= res_nxt;
          count_r <= count_nxt;
          if (go_pass2) begin
            pass2_r <= 1'b1;
            ff_r    <= 1'b0;
            scan_r  <= '0;
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.status        = out_r.status;
  assign out_item.result_offset = out_r.off;
  assign out_item.moved         = out_r.moved;
  assign out_item.copy_length   = out_r.len;

  // The table never empties and never overflows the ring.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");

  // A full revolution always ends in the edit cycle, with the ring realigned.
  a_rev_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_r == SCAN_LAST |=> state_r == ST_EDIT && scan_r == '0)
    else $error("scan revolution did not end in the edit cycle");

  // A relocated block is only ever reported on success.
  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.moved |-> out_r.status == STS_OK)
    else $error("moved flag set on a failed item");

endmodule
